@@ hw/rtl/btnhr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnhr_pkg
// shared types and constants of the button hold/release tracker
// ----------------------------------------------------------------------------
package btnhr_pkg;

	localparam int NumButtonsDef = 4;
	localparam int ButtonW       = 2;
	localparam int TpsW          = 10;
	localparam int DbtW          = 8;
	localparam int SecsW         = 16;
	localparam int CfgIdxW       = 1;
	localparam int CfgDataW      = 10;

	localparam logic [TpsW-1:0] TpsReset = TpsW'(100);
	localparam logic [DbtW-1:0] DbtReset = DbtW'(1);

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TICKS_PER_SECOND = 1'b0,
		CFG_DEBOUNCE_TICKS   = 1'b1
	} cfg_idx_t;

	// command from the processing stage to one button lane
	typedef struct packed {
		logic            en;
		logic            tick;
		logic            irq;
		logic [TpsW-1:0] tps;
		logic [DbtW-1:0] dbt;
	} lane_cmd_t;

	// event a lane produces for one item
	typedef struct packed {
		logic             valid;
		logic             pressed;
		logic [SecsW-1:0] secs;
	} evt_t;

endpackage

@@ hw/rtl/btnhr_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnhr_lane
// state and update logic of one button: press, hold seconds, debounce mask,
// release countdown
// ----------------------------------------------------------------------------
module btnhr_lane
	import btnhr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lane_cmd_t cmd,
	output evt_t      evt
);

	logic             pressed_q, masked_q, armed_q;
	logic [DbtW-1:0]  mask_cnt_q, rel_cnt_q;
	logic [TpsW-1:0]  sub_q;
	logic [SecsW-1:0] held_q, rep_q;

	logic             pressed_d, masked_d, armed_d;
	logic [DbtW-1:0]  mask_cnt_d, rel_cnt_d, mask_dec, rel_dec;
	logic [TpsW-1:0]  sub_d;
	logic [SecsW-1:0] held_d, rep_d;
	logic [TpsW:0]    sub_inc;

	always_comb begin
		pressed_d  = pressed_q;
		masked_d   = masked_q;
		armed_d    = armed_q;
		mask_cnt_d = mask_cnt_q;
		rel_cnt_d  = rel_cnt_q;
		sub_d      = sub_q;
		held_d     = held_q;
		rep_d      = rep_q;
		evt        = '0;
		sub_inc    = {1'b0, sub_q} + 1'b1;
		mask_dec   = (mask_cnt_q != '0) ? mask_cnt_q - 1'b1 : '0;
		rel_dec    = (rel_cnt_q != '0) ? rel_cnt_q - 1'b1 : '0;
		if (cmd.irq && !masked_q) begin
			if (!pressed_q) begin
				evt.valid = 1'b1;
				evt.pressed = 1'b1;
				pressed_d = 1'b1;
				sub_d = '0;
				held_d = '0;
				rep_d = '0;
			end else begin
				if (held_q > rep_q) begin
					evt.valid = 1'b1;
					evt.pressed = 1'b1;
					evt.secs = held_q;
					rep_d = held_q;
				end
				armed_d = 1'b0;
				rel_cnt_d = '0;
			end
			masked_d = 1'b1;
			mask_cnt_d = cmd.dbt;
		end else if (cmd.tick) begin
			if (pressed_q) begin
				if (sub_inc >= {1'b0, cmd.tps}) begin
					sub_d = '0;
					if (held_q != '1)
						held_d = held_q + 1'b1;
				end else begin
					sub_d = sub_inc[TpsW-1:0];
				end
			end
			if (masked_q) begin
				mask_cnt_d = mask_dec;
				if (mask_dec == '0) begin
					masked_d = 1'b0;
					armed_d = 1'b1;
					rel_cnt_d = cmd.dbt;
				end
			end else if (armed_q) begin
				rel_cnt_d = rel_dec;
				if (rel_dec == '0) begin
					armed_d = 1'b0;
					pressed_d = 1'b0;
					evt.valid = 1'b1;
					evt.secs = held_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q  <= 1'b0;
			masked_q   <= 1'b0;
			armed_q    <= 1'b0;
			mask_cnt_q <= '0;
			rel_cnt_q  <= '0;
			sub_q      <= '0;
			held_q     <= '0;
			rep_q      <= '0;
		end else if (cmd.en) begin
			pressed_q  <= pressed_d;
			masked_q   <= masked_d;
			armed_q    <= armed_d;
			mask_cnt_q <= mask_cnt_d;
			rel_cnt_q  <= rel_cnt_d;
			sub_q      <= sub_d;
			held_q     <= held_d;
			rep_q      <= rep_d;
		end
	end

endmodule

@@ hw/rtl/button_hold_release_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_hold_release_tracker
// press / hold / release events for push buttons from interrupts and ticks
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall, mode, button): mode 0 is one time tick,
// mode 1 an interrupt from the given button
// output channel (out_valid / out_stall): one event per transfer, with
// button_id, pressed, seconds_held; last marks the final event of one input
// an accepted item is processed while it sits in the input register; its
// events enter the queue when the stage moves on, and the first one is
// offered from then on
// items are taken every cycle while the two-entry event queue has room; an
// item leaves a bundle of up to four events, drained one per cycle while the
// receiver does not stall, so a tick that releases k buttons gives k events
// items that cause no event pass without touching the queue
// when the receiver stalls, the queue fills and in_stall rises once both
// entries hold undelivered events; the output event holds steady meanwhile
// reset clears all button state, empties the queue and loads the register
// defaults (100 ticks per second, debounce of one tick)
// config writes (cfg_wr_en, cfg_index, cfg_data) take effect the next cycle
// ----------------------------------------------------------------------------
module button_hold_release_tracker
	import btnhr_pkg::*;
#(
	parameter int NUM_BUTTONS = NumButtonsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [ButtonW-1:0]  button,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ButtonW-1:0]  button_id,
	output logic                pressed,
	output logic [SecsW-1:0]    seconds_held,
	output logic                last,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// only the buttons the index field can reach ever become active
	localparam int MaxReach = 1 << ButtonW;
	localparam int NumLanes = (NUM_BUTTONS < MaxReach) ? NUM_BUTTONS : MaxReach;
	localparam int LaneW    = (NumLanes > 1) ? $clog2(NumLanes) : 1;
	localparam int QDepth   = 2;
	localparam int QPtrW    = 1;
	localparam int QCntW    = 2;

	// configuration registers
	logic [TpsW-1:0] tps_q;
	logic [DbtW-1:0] dbt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TpsReset;
			dbt_q <= DbtReset;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TICKS_PER_SECOND: tps_q <= cfg_data[TpsW-1:0];
				CFG_DEBOUNCE_TICKS:   dbt_q <= cfg_data[DbtW-1:0];
				default: ;
			endcase
		end
	end

	// zero settings act as one
	logic [TpsW-1:0] tps_eff;
	logic [DbtW-1:0] dbt_eff;
	assign tps_eff = (tps_q == '0) ? TpsW'(1) : tps_q;
	assign dbt_eff = (dbt_q == '0) ? DbtW'(1) : dbt_q;

	// input register
	logic               valid_s1;
	logic               mode_s1;
	logic [ButtonW-1:0] button_s1;
	logic               in_xfer, adv_s1;

	logic [QCntW-1:0] q_cnt_q;
	logic [QPtrW-1:0] q_wr_q, q_rd_q;

	// the stage moves on whenever the queue can take a whole bundle
	assign adv_s1   = valid_s1 && (q_cnt_q != QCntW'(QDepth));
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!valid_s1 || adv_s1)
			valid_s1 <= in_xfer;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1   <= mode;
			button_s1 <= button;
		end
	end

	// per-button lanes
	evt_t bundle [NumLanes];
	logic [NumLanes-1:0] bundle_hit;

	for (genvar i = 0; i < NumLanes; i++) begin : g_lane
		lane_cmd_t cmd;
		always_comb begin
			cmd.en   = adv_s1;
			cmd.tick = !mode_s1;
			cmd.irq  = mode_s1 && (button_s1 == ButtonW'(i));
			cmd.tps  = tps_eff;
			cmd.dbt  = dbt_eff;
		end
		btnhr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.evt    (bundle[i])
		);
		assign bundle_hit[i] = bundle[i].valid;
	end

	// event queue: each entry holds all events of one item
	evt_t q_mem [QDepth][NumLanes];
	logic q_push, q_pop, out_xfer;
	logic [NumLanes-1:0] head_mask, rest_mask;
	logic [LaneW-1:0]    sel;

	assign q_push   = adv_s1 && (bundle_hit != '0);
	assign out_valid = (q_cnt_q != '0);
	assign out_xfer = out_valid && !out_stall;

	// lowest pending button of the head entry goes first
	always_comb begin
		sel = '0;
		for (int i = NumLanes - 1; i >= 0; i--) begin
			head_mask[i] = q_mem[q_rd_q][i].valid;
		end
		for (int i = NumLanes - 1; i >= 0; i--) begin
			if (head_mask[i])
				sel = LaneW'(i);
		end
		rest_mask      = head_mask;
		rest_mask[sel] = 1'b0;
	end

	assign q_pop        = out_xfer && (rest_mask == '0);
	assign button_id    = ButtonW'(sel);
	assign pressed      = q_mem[q_rd_q][sel].pressed;
	assign seconds_held = q_mem[q_rd_q][sel].secs;
	assign last         = (rest_mask == '0);

	always_ff @(posedge clk) begin
		if (out_xfer)
			q_mem[q_rd_q][sel].valid <= 1'b0;
		if (q_push) begin
			for (int i = 0; i < NumLanes; i++)
				q_mem[q_wr_q][i] <= bundle[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0;
			q_wr_q  <= '0;
			q_rd_q  <= '0;
		end else begin
			if (q_push)
				q_wr_q <= q_wr_q + 1'b1;
			if (q_pop)
				q_rd_q <= q_rd_q + 1'b1;
			case ({q_push, q_pop})
				2'b10:   q_cnt_q <= q_cnt_q + 1'b1;
				2'b01:   q_cnt_q <= q_cnt_q - 1'b1;
				default: q_cnt_q <= q_cnt_q;
			endcase
		end
	end

endmodule

@@ bench/btnhr_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnhr_tb_pkg
// item kinds shared by the tracker bench and its event checker
// ----------------------------------------------------------------------------
package btnhr_tb_pkg;

	typedef enum logic {
		ITEM_TICK = 1'b0,
		ITEM_IRQ  = 1'b1
	} item_kind_t;

endpackage

@@ bench/btnhr_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnhr_event_checker
// follows every transfer of the tracker, keeps its own copy of the button
// state and registers, and compares each event with the one it predicts
// ----------------------------------------------------------------------------
module btnhr_event_checker
	import btnhr_pkg::*;
	import btnhr_tb_pkg::*;
#(
	parameter int NBTN = NumButtonsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                mode,
	input  logic [ButtonW-1:0]  button,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [ButtonW-1:0]  button_id,
	input  logic                pressed,
	input  logic [SecsW-1:0]    seconds_held,
	input  logic                last,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  fails,
	output int                  pending
);

	typedef struct packed {
		logic [ButtonW-1:0] id;
		logic               down;
		logic [SecsW-1:0]   secs;
		logic               last;
	} btn_event_t;

	btn_event_t awaited_events[$];
	int         events_seen;

	logic [TpsW-1:0]  tps_reg;
	logic [DbtW-1:0]  dbt_reg;
	logic             btn_down   [NBTN];
	logic             btn_masked [NBTN];
	logic [DbtW-1:0]  mask_left  [NBTN];
	logic             rel_armed  [NBTN];
	logic [DbtW-1:0]  rel_left   [NBTN];
	logic [TpsW-1:0]  sub_ticks  [NBTN];
	logic [SecsW-1:0] secs       [NBTN];
	logic [SecsW-1:0] secs_sent  [NBTN];

	function automatic btn_event_t make_event(input logic [ButtonW-1:0] id, input logic down,
			input logic [SecsW-1:0] s);
		btn_event_t ev;
		ev.id   = id;
		ev.down = down;
		ev.secs = s;
		ev.last = 1'b0;
		return ev;
	endfunction

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: event %0d: %s is %0h, %0h predicted", $time, events_seen, field, got, want);
		fails++;
	endtask

	task automatic predict_button_events(input item_kind_t kind, input logic [ButtonW-1:0] b);
		btn_event_t      bundle[$];
		int unsigned     tps_eff;
		int unsigned     nxt;
		logic [DbtW-1:0] dbt_eff;
		dbt_eff = (dbt_reg == '0) ? DbtW'(1) : dbt_reg;
		tps_eff = (tps_reg == '0) ? 1 : tps_reg;
		if (kind == ITEM_IRQ) begin
			// interrupts on a masked button, or on one without a lane, change nothing
			if (int'(b) < NBTN && !btn_masked[b]) begin
				if (!btn_down[b]) begin
					bundle.push_back(make_event(b, 1'b1, '0));
					btn_down[b]  = 1'b1;
					sub_ticks[b] = '0;
					secs[b]      = '0;
					secs_sent[b] = '0;
				end else begin
					if (secs[b] > secs_sent[b]) begin
						bundle.push_back(make_event(b, 1'b1, secs[b]));
						secs_sent[b] = secs[b];
					end
					rel_armed[b] = 1'b0;
					rel_left[b]  = '0;
				end
				btn_masked[b] = 1'b1;
				mask_left[b]  = dbt_eff;
			end
		end else begin
			for (int i = 0; i < NBTN; i++) begin
				if (btn_down[i]) begin
					nxt = sub_ticks[i] + 1;
					if (nxt >= tps_eff) begin
						sub_ticks[i] = '0;
						if (secs[i] != '1)
							secs[i] = secs[i] + 1'b1;
					end else begin
						sub_ticks[i] = TpsW'(nxt);
					end
				end
				if (btn_masked[i]) begin
					if (mask_left[i] != '0)
						mask_left[i] = mask_left[i] - 1'b1;
					if (mask_left[i] == '0) begin
						btn_masked[i] = 1'b0;
						rel_armed[i]  = 1'b1;
						rel_left[i]   = dbt_eff;
					end
				end else if (rel_armed[i]) begin
					if (rel_left[i] != '0)
						rel_left[i] = rel_left[i] - 1'b1;
					if (rel_left[i] == '0) begin
						rel_armed[i] = 1'b0;
						bundle.push_back(make_event(ButtonW'(i), 1'b0, secs[i]));
						btn_down[i] = 1'b0;
					end
				end
			end
		end
		if (bundle.size() > 0)
			bundle[bundle.size() - 1].last = 1'b1;
		foreach (bundle[k])
			awaited_events.push_back(bundle[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		btn_event_t want;
		if (!arst_n) begin
			awaited_events.delete();
			tps_reg = TpsReset;
			dbt_reg = DbtReset;
			for (int i = 0; i < NBTN; i++) begin
				btn_down[i]   = 1'b0;
				btn_masked[i] = 1'b0;
				mask_left[i]  = '0;
				rel_armed[i]  = 1'b0;
				rel_left[i]   = '0;
				sub_ticks[i]  = '0;
				secs[i]       = '0;
				secs_sent[i]  = '0;
			end
			events_seen = 0;
			fails       = 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TICKS_PER_SECOND: tps_reg = cfg_data[TpsW-1:0];
					CFG_DEBOUNCE_TICKS:   dbt_reg = cfg_data[DbtW-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_button_events(item_kind_t'(mode), button);
			if (out_valid && !out_stall) begin
				if (awaited_events.size() == 0) begin
					report("event with nothing awaited, button_id", 32'(button_id), '0);
				end else begin
					want = awaited_events.pop_front();
					if (button_id !== want.id)
						report("button_id", 32'(button_id), 32'(want.id));
					if (pressed !== want.down)
						report("pressed", 32'(pressed), 32'(want.down));
					if (seconds_held !== want.secs)
						report("seconds_held", 32'(seconds_held), 32'(want.secs));
					if (last !== want.last)
						report("last", 32'(last), 32'(want.last));
				end
				events_seen++;
			end
			pending <= awaited_events.size();
		end
	end

endmodule

@@ bench/tb_button_hold_release_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_hold_release_tracker
// drives ticks and button interrupts into the tracker in bursts, stalls the
// event side on its own pattern, and lets the event checker judge every
// transfer; directed press/hold/release cases come first, then random mixes
// under several register settings
// ----------------------------------------------------------------------------
module tb_button_hold_release_tracker;
	import btnhr_pkg::*;
	import btnhr_tb_pkg::*;

	// cycles without any transfer or register write before giving up
	localparam int QUIET_LIMIT = 2000;
	// pipeline depth of the block plus some margin
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_kind_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic                mode         = 1'b0;
	logic [ButtonW-1:0]  button       = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [ButtonW-1:0]  button_id;
	logic                pressed;
	logic [SecsW-1:0]    seconds_held;
	logic                last;
	logic                cfg_wr_en    = 1'b0;
	cfg_idx_t            cfg_index    = CFG_TICKS_PER_SECOND;
	logic [CfgDataW-1:0] cfg_data     = '0;

	int                  fails;
	int                  pending;
	int                  burst_left   = 0;
	int unsigned         quiet_cycles = 0;
	int                  stall_seg    = 0;
	int                  stall_phase  = 0;
	stall_kind_t         stall_kind   = STALL_NONE;

	button_hold_release_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.button       (button),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.button_id    (button_id),
		.pressed      (pressed),
		.seconds_held (seconds_held),
		.last         (last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	btnhr_event_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.button       (button),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.button_id    (button_id),
		.pressed      (pressed),
		.seconds_held (seconds_held),
		.last         (last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fails        (fails),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// event side: segments of no stall, random stall or a fixed duty pattern
	always @(posedge clk) begin
		if (stall_seg == 0) begin
			stall_seg  = $urandom_range(16, 80);
			stall_kind = stall_kind_t'($urandom_range(0, 2));
		end
		stall_seg--;
		stall_phase = (stall_phase + 1) % 5;
		case (stall_kind)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
			default:      out_stall <= (stall_phase < 3);
		endcase
	end

	// watchdog: a hang shows up as a long run of edges with no transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("button_hold_release_tracker test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one item per transfer; valid stays high inside a burst and only drops
	// for the gap between bursts, so it is never lowered and raised in one step
	task automatic send_item(input item_kind_t kind, input logic [ButtonW-1:0] b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		mode     <= kind;
		button   <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
	endtask

	// stop sending and wait until every predicted event has been seen, then
	// wait out the settle margin so the pipeline is clear
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers are written back to back, only while the block is idle
	task automatic set_config(input int unsigned tps, input int unsigned dbt);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_TICKS_PER_SECOND;
		cfg_data  <= CfgDataW'(tps);
		@(posedge clk);
		cfg_index <= CFG_DEBOUNCE_TICKS;
		cfg_data  <= CfgDataW'(dbt);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly ticks with interrupts on random buttons mixed in
	task automatic random_run(input int n_items);
		repeat (n_items) begin
			if ($urandom_range(0, 9) < 3)
				send_item(ITEM_IRQ, ButtonW'($urandom_range(0, 3)));
			else
				send_item(ITEM_TICK, ButtonW'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// press, masked interrupt, hold without growth, growth report, and a
		// tick that releases all four buttons at once
		set_config(2, 1);
		send_item(ITEM_IRQ, ButtonW'(0));
		send_item(ITEM_IRQ, ButtonW'(0));
		send_item(ITEM_TICK, ButtonW'(0));
		send_item(ITEM_IRQ, ButtonW'(0));
		send_item(ITEM_TICK, ButtonW'(3));
		send_item(ITEM_IRQ, ButtonW'(0));
		send_item(ITEM_IRQ, ButtonW'(1));
		send_item(ITEM_IRQ, ButtonW'(2));
		send_item(ITEM_IRQ, ButtonW'(3));
		send_item(ITEM_TICK, ButtonW'(1));
		send_item(ITEM_TICK, ButtonW'(2));
		settle();

		// sub-second count left above a lowered rate completes on the next tick
		set_config(5, 3);
		send_item(ITEM_IRQ, ButtonW'(1));
		repeat (4) send_item(ITEM_TICK, ButtonW'(0));
		settle();
		set_config(2, 3);
		send_item(ITEM_TICK, ButtonW'(0));
		send_item(ITEM_IRQ, ButtonW'(1));
		repeat (6) send_item(ITEM_TICK, ButtonW'(0));
		settle();

		// random mixes; zero rate and zero debounce both act as one
		set_config(0, 0);
		random_run(30);
		settle();
		set_config(1000, 2);
		random_run(30);
		settle();
		set_config(3, 1);
		random_run(30);
		settle();
		set_config(23, 4);
		random_run(30);
		settle();

		set_config(2, 1);
		random_run(25);
		settle();
		repeat (8) @(posedge clk);

		if (fails == 0) begin
			$display("button_hold_release_tracker test passed");
		end else begin
			$display("button_hold_release_tracker test failed");
		end
		$finish;
	end

endmodule

@@ button_hold_release_tracker.f @@
hw/rtl/btnhr_pkg.sv
hw/rtl/btnhr_lane.sv
hw/rtl/button_hold_release_tracker.sv
bench/btnhr_tb_pkg.sv
bench/btnhr_event_checker.sv
bench/tb_button_hold_release_tracker.sv
